// ----- hw/rtl/rfcs_pkg.sv -----
// shared constants and types for the rotated filled circle span rasterizer
`default_nettype none

package rfcs_pkg;

  localparam int IN_W      = 24;  // rel_x / rel_y width
  localparam int TRIG_W    = 16;  // cos / sin width
  localparam int TRIG_FRAC = 14;
  localparam int RAD_W     = 10;
  localparam int SPAN_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam int ROW_MIN  = 12;
  localparam int ROW_MAX  = 63;
  localparam int COL_MAX  = 62;
  localparam int CENTER_X = 31;
  localparam int CENTER_Y = ROW_MIN + 26;

  localparam logic [CFG_IDX_W-1:0] CFG_COS_ROT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_ROT = 1'd1;

  localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SIN_RESET = 16'sd0;

  typedef struct packed {
    logic [SPAN_W-1:0] x;
    logic [SPAN_W-1:0] y;
    logic [SPAN_W-1:0] len;
  } span_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rotated_filled_circle_spans.sv -----
// top level: rotate a body position, then emit clipped circle spans row by row
//
// sequence: after an item is accepted, the rotation, truncation, row clip and r*r, d*d and h2
//   steps run in turn; each covered screen row (at most 52 rows) then takes a square root and
//   a span step, and a flush step releases the final span
// one body at a time: in_ready stays low through the bit-serial rotation multiply and the
//   square root shared by all rows of the body
// reset: synchronous active-low rst_n idles the sequencer, drops out_valid and
//   restores cos_rot to 1.0 and sin_rot to 0
`default_nettype none

module rotated_filled_circle_spans
  import rfcs_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration write port
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [TRIG_W-1:0]           cfg_data,
  // body items
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [IN_W-1:0]      in_rel_x,
  input  wire logic signed [IN_W-1:0]      in_rel_y,
  input  wire logic [RAD_W-1:0]            in_radius,
  // span items
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [SPAN_W-1:0]                out_span_x,
  output logic [SPAN_W-1:0]                out_span_y,
  output logic [SPAN_W-1:0]                out_span_len,
  output logic                             out_last
);

  // rotation accumulator holds dx*c - dy*s exactly
  localparam int ACC_W = IN_W + TRIG_W + 1;
  // total fraction bits removed after the rotation
  localparam int SH    = COORD_FRAC_BITS + TRIG_FRAC;
  // screen position width: rotated value plus room for center and radius
  localparam int PW    = ACC_W - SH + 2;
  localparam int H2_W  = 2 * RAD_W;
  localparam int REM_W = RAD_W + 3;
  localparam int RCNT_W = $clog2(TRIG_W);
  localparam int SCNT_W = $clog2(RAD_W);

  localparam logic [RCNT_W-1:0] ROT_LAST = RCNT_W'(TRIG_W - 1);
  localparam logic [SCNT_W-1:0] SQ_LAST  = SCNT_W'(RAD_W - 1);

  localparam logic signed [PW-1:0] ROW_MIN_S  = PW'(ROW_MIN);
  localparam logic signed [PW-1:0] ROW_MAX_S  = PW'(ROW_MAX);
  localparam logic signed [PW-1:0] COL_MAX_S  = PW'(COL_MAX);
  localparam logic signed [PW-1:0] CENTER_X_S = PW'(CENTER_X);
  localparam logic signed [PW-1:0] CENTER_Y_S = PW'(CENTER_Y);
  localparam logic signed [PW-1:0] ZERO_S     = '0;

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a body
    S_ROT,    // bit-serial rotation, one trig bit per cycle, sign bit first
    S_DIV,    // truncate toward zero and add the screen center
    S_BOUND,  // clip the row range, drop bodies with no rows
    S_PREP,   // r*r and d*d for the first row
    S_H2,     // h2 = r*r - d*d, start the square root
    S_SQRT,   // digit-by-digit square root, radicand bits taken in pairs
    S_SPAN,   // clip columns, hand the previous span on, step to the next row
    S_FLUSH   // release the held span marked last
  } state_t;

  state_t state_r;

  // camera registers
  logic signed [TRIG_W-1:0] cos_r, sin_r;

  // body operands
  logic signed [IN_W-1:0]   dx_r, dy_r;
  logic [RAD_W-1:0]         r_r;
  logic [TRIG_W-1:0]        cs_sh_r, sn_sh_r;  // trig bits, shifted out msb first
  logic [RCNT_W-1:0]        rot_cnt_r;
  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r;

  // screen position and row walk
  logic signed [PW-1:0]     px_r, py_r;
  logic [SPAN_W-1:0]        y_r, bot_r;
  logic signed [RAD_W:0]    d_r;               // row minus center row
  logic [H2_W-1:0]          rr_r, dd_r, h2_r;

  // square root
  logic [H2_W-1:0]          sq_sh_r;
  logic [REM_W-1:0]         rem_r;
  logic [RAD_W-1:0]         root_r;
  logic [SCNT_W-1:0]        sq_cnt_r;

  // one span held back so the final one can be marked
  span_t                    pend_r;
  logic                     pend_v_r;
  span_t                    out_r;
  logic                     out_valid_r, out_last_r;

  // ---------------------------------------------------------------- rotation step
  logic signed [ACC_W-1:0]  dx_ext, dy_ext, tx, ty, acc_x_nxt, acc_y_nxt;
  logic                     cb, sb, sign_step;

  always_comb begin
    dx_ext    = {{(ACC_W-IN_W){dx_r[IN_W-1]}}, dx_r};
    dy_ext    = {{(ACC_W-IN_W){dy_r[IN_W-1]}}, dy_r};
    cb        = cs_sh_r[TRIG_W-1];
    sb        = sn_sh_r[TRIG_W-1];
    sign_step = (rot_cnt_r == '0);
    tx        = (cb ? dx_ext : '0) - (sb ? dy_ext : '0);
    ty        = (sb ? dx_ext : '0) + (cb ? dy_ext : '0);
    // the two's complement sign bit carries negative weight
    if (sign_step) begin
      tx = -tx;
      ty = -ty;
    end
    acc_x_nxt = {acc_x_r[ACC_W-2:0], 1'b0} + tx;
    acc_y_nxt = {acc_y_r[ACC_W-2:0], 1'b0} + ty;
  end

  // ---------------------------------------------------- truncation toward zero
  logic signed [ACC_W-1:0]  qx_full, qy_full;
  logic signed [PW-1:0]     rx, ry, px_nxt, py_nxt;

  always_comb begin
    qx_full = acc_x_r >>> SH;
    qy_full = acc_y_r >>> SH;
    rx = qx_full[PW-1:0] + PW'(acc_x_r[ACC_W-1] && (|acc_x_r[SH-1:0]));
    ry = qy_full[PW-1:0] + PW'(acc_y_r[ACC_W-1] && (|acc_y_r[SH-1:0]));
    px_nxt = rx + CENTER_X_S;
    py_nxt = ry + CENTER_Y_S;
  end

  // ---------------------------------------------------------------- row range
  logic signed [PW-1:0]     r_ext, top_raw, bot_raw, top_c, bot_c, d0;
  logic                     rows_empty;

  always_comb begin
    r_ext      = {{(PW-RAD_W){1'b0}}, r_r};
    top_raw    = py_r - r_ext;
    bot_raw    = py_r + r_ext;
    top_c      = (top_raw < ROW_MIN_S) ? ROW_MIN_S : top_raw;
    bot_c      = (bot_raw > ROW_MAX_S) ? ROW_MAX_S : bot_raw;
    rows_empty = (top_c > bot_c);
    d0         = top_c - py_r;  // within -r..r whenever rows exist
  end

  logic [RAD_W-1:0]         d_mag;
  assign d_mag = d_r[RAD_W] ? RAD_W'(-d_r) : d_r[RAD_W-1:0];

  // next row: (d+1)^2 = d^2 + 2d + 1
  logic [H2_W-1:0]          h2_step;
  assign h2_step = h2_r - {{(H2_W-RAD_W-2){d_r[RAD_W]}}, d_r, 1'b1};

  // ---------------------------------------------------------------- sqrt digit
  logic [REM_W-1:0]         rem_sh, trial;
  logic                     take;

  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], sq_sh_r[H2_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    take   = (rem_sh >= trial);
  end

  // ---------------------------------------------------------------- column clip
  logic signed [PW-1:0]     h_ext, x1, x2, x1c, x2c;
  logic                     vis, slot_free, out_load;
  span_t                    span_new;

  always_comb begin
    h_ext = {{(PW-RAD_W){1'b0}}, root_r};
    x1    = px_r - h_ext;
    x2    = px_r + h_ext;
    vis   = !((x2 < ZERO_S) || (x1 > COL_MAX_S));
    x1c   = (x1 < ZERO_S) ? ZERO_S : x1;
    x2c   = (x2 > COL_MAX_S) ? COL_MAX_S : x2;
    span_new.x   = x1c[SPAN_W-1:0];
    span_new.y   = y_r;
    span_new.len = x2c[SPAN_W-1:0] - x1c[SPAN_W-1:0] + SPAN_W'(1);
  end

  // output register is free when empty or being taken this cycle
  assign slot_free = !out_valid_r || out_ready;

  // held span moves to the output: pushed out by a new visible span or flushed at the end
  assign out_load = slot_free && pend_v_r &&
                    (((state_r == S_SPAN) && vis) || (state_r == S_FLUSH));

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cos_r       <= COS_RESET;
      sin_r       <= SIN_RESET;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COS_ROT: cos_r <= cfg_data;
          CFG_SIN_ROT: sin_r <= cfg_data;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            dx_r      <= in_rel_x;
            dy_r      <= in_rel_y;
            r_r       <= in_radius;
            cs_sh_r   <= cos_r;
            sn_sh_r   <= sin_r;
            rot_cnt_r <= '0;
            acc_x_r   <= '0;
            acc_y_r   <= '0;
            state_r   <= S_ROT;
          end
        end

        S_ROT: begin
          acc_x_r   <= acc_x_nxt;
          acc_y_r   <= acc_y_nxt;
          cs_sh_r   <= {cs_sh_r[TRIG_W-2:0], 1'b0};
          sn_sh_r   <= {sn_sh_r[TRIG_W-2:0], 1'b0};
          rot_cnt_r <= rot_cnt_r + RCNT_W'(1);
          if (rot_cnt_r == ROT_LAST) begin
            state_r <= S_DIV;
          end
        end

        S_DIV: begin
          px_r    <= px_nxt;
          py_r    <= py_nxt;
          state_r <= S_BOUND;
        end

        S_BOUND: begin
          y_r   <= top_c[SPAN_W-1:0];
          bot_r <= bot_c[SPAN_W-1:0];
          d_r   <= d0[RAD_W:0];
          state_r <= rows_empty ? S_IDLE : S_PREP;
        end

        S_PREP: begin
          rr_r    <= H2_W'(r_r) * H2_W'(r_r);
          dd_r    <= H2_W'(d_mag) * H2_W'(d_mag);
          state_r <= S_H2;
        end

        S_H2: begin
          h2_r     <= rr_r - dd_r;
          sq_sh_r  <= rr_r - dd_r;
          rem_r    <= '0;
          root_r   <= '0;
          sq_cnt_r <= '0;
          state_r  <= S_SQRT;
        end

        S_SQRT: begin
          sq_sh_r  <= {sq_sh_r[H2_W-3:0], 2'b00};
          sq_cnt_r <= sq_cnt_r + SCNT_W'(1);
          if (take) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[RAD_W-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[RAD_W-2:0], 1'b0};
          end
          if (sq_cnt_r == SQ_LAST) begin
            state_r <= S_SPAN;
          end
        end

        S_SPAN: begin
          // a visible span must wait while the held one cannot move on
          if (!(vis && pend_v_r && !slot_free)) begin
            if (vis) begin
              if (pend_v_r) begin
                out_r       <= pend_r;
                out_last_r  <= 1'b0;
              end
              pend_r   <= span_new;
              pend_v_r <= 1'b1;
            end
            if (y_r == bot_r) begin
              state_r <= S_FLUSH;
            end else begin
              y_r      <= y_r + SPAN_W'(1);
              d_r      <= d_r + (RAD_W+1)'(1);
              h2_r     <= h2_step;
              sq_sh_r  <= h2_step;
              rem_r    <= '0;
              root_r   <= '0;
              sq_cnt_r <= '0;
              state_r  <= S_SQRT;
            end
          end
        end

        S_FLUSH: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_r       <= pend_r;
            out_last_r  <= 1'b1;
            pend_v_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_span_x   = out_r.x;
  assign out_span_y   = out_r.y;
  assign out_span_len = out_r.len;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rfcs_checker.sv -----
// port-level checks for the circle span rasterizer, bound to the top level
`default_nettype none

module rfcs_checker
  import rfcs_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SPAN_W-1:0]      out_span_x,
  input wire logic [SPAN_W-1:0]      out_span_y,
  input wire logic [SPAN_W-1:0]      out_span_len,
  input wire logic                   out_last
);

  // stalled span item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_span_x) && $stable(out_span_y)
      && $stable(out_span_len) && $stable(out_last))
    else $error("span item changed while stalled");

  // span stays on screen rows and is never empty
  a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_span_len != '0) && (out_span_y >= SPAN_W'(ROW_MIN)))
    else $error("span row or length out of range");

  // right end of the span stays within the last column
  a_span_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_span_x} + {1'b0, out_span_len}) <= (SPAN_W+1)'(COL_MAX + 1))
    else $error("span runs past the right edge");

  // body input is closed right after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // a body still has spans to deliver while a non-final span is shown
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open before the final span");

endmodule

bind rotated_filled_circle_spans rfcs_checker u_rfcs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_span_x   (out_span_x),
  .out_span_y   (out_span_y),
  .out_span_len (out_span_len),
  .out_last     (out_last)
);

`default_nettype wire
